/* hw/rtl/ps2mc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the PS/2 mouse packet cursor tracker.
// No dependencies; imported by the front, back and top-level modules of the block.
package ps2mc_pkg;

	// Default coordinate width of the cursor position
	localparam int COORD_BITS_DEF = 12;

	// Depth of the packet queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Screen size register width and reset values
	localparam int SIZE_BITS = 13;
	localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RST  = 13'd1024;
	localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RST = 13'd768;

	// Header byte bit positions
	localparam int HDR_ALWAYS_ONE_BIT = 3;
	localparam int HDR_X_SIGN_BIT     = 4;
	localparam int HDR_Y_SIGN_BIT     = 5;
	localparam int HDR_X_OVF_BIT      = 6;
	localparam int HDR_Y_OVF_BIT      = 7;
	localparam int BUTTON_BITS        = 3;
	localparam int DELTA_BITS         = 9;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_SCREEN_WIDTH  = 1'b0,
		CFG_SCREEN_HEIGHT = 1'b1
	} cfg_reg_t;

	// Position within a three-byte packet
	typedef enum logic [2:0] {
		POS_HDR = 3'b001,
		POS_X   = 3'b010,
		POS_Y   = 3'b100
	} byte_pos_t;

	// One assembled packet
	typedef struct packed {
		logic [7:0] y_byte;
		logic [7:0] x_byte;
		logic [7:0] header;
	} pkt_t;

	// Highest legal coordinate for a screen size: size-1, zero counts as one,
	// saturated to the coordinate range.
	function automatic logic [15:0] size_to_limit(logic [SIZE_BITS-1:0] size, int cb);
		logic [15:0] lim;
		logic [16:0] cmax;
		begin
			lim  = (size == '0) ? 16'd0 : 16'(size - 13'd1);
			cmax = (17'd1 << cb) - 17'd1;
			if ({1'b0, lim} > cmax) begin
				lim = cmax[15:0];
			end
			return lim;
		end
	endfunction

endpackage

/* hw/rtl/ps2mc_front.sv */
`timescale 1ns / 1ps
// Front end: takes controller bytes, drops non-aux bytes, frames packets.
// Depends on ps2mc_pkg; pushes complete packets into the packet queue.
module ps2mc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [7:0]     data_byte,
	input  logic           from_aux,
	input  logic           queue_full,
	output logic           push,
	output ps2mc_pkg::pkt_t push_pkt
);
	import ps2mc_pkg::*;

	byte_pos_t  pos_q;
	logic [7:0] hdr_q;
	logic [7:0] xb_q;
	logic       take;

	// A word is taken whenever the queue has room; only aux words count
	assign in_ready = ~queue_full;
	assign take     = in_valid & in_ready & from_aux;
	assign push     = take & (pos_q == POS_Y);

	assign push_pkt.header = hdr_q;
	assign push_pkt.x_byte = xb_q;
	assign push_pkt.y_byte = data_byte;

	// Packet framing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HDR;
		end else if (take) begin
			case (pos_q)
				POS_X: begin
					pos_q <= POS_Y;
				end
				POS_Y: begin
					pos_q <= POS_HDR;
				end
				default: begin
					// header without the always-one bit: stay to resync
					if (data_byte[HDR_ALWAYS_ONE_BIT]) begin
						pos_q <= POS_X;
					end else begin
						pos_q <= POS_HDR;
					end
				end
			endcase
		end
	end

	// Header and X byte capture
	always_ff @(posedge clk) begin
		if (take) begin
			if (pos_q == POS_X) begin
				xb_q <= data_byte;
			end else if (pos_q != POS_Y && data_byte[HDR_ALWAYS_ONE_BIT]) begin
				hdr_q <= data_byte;
			end
		end
	end

endmodule

/* hw/rtl/ps2mc_fifo.sv */
`timescale 1ns / 1ps
// Small register queue carrying packets from front to back.
// Depends on nothing but its parameters.
module ps2mc_fifo #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("packet queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("packet queue read while empty");

endmodule

/* hw/rtl/ps2mc_back.sv */
`timescale 1ns / 1ps
// Back end: decodes packets, moves and clamps the cursor, holds the result.
// Depends on ps2mc_pkg; reads packets from the packet queue.
module ps2mc_back #(
	parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ps2mc_pkg::pkt_t       pkt,
	input  logic                  queue_empty,
	output logic                  pop,
	input  logic [COORD_BITS-1:0] lim_x,
	input  logic [COORD_BITS-1:0] lim_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] cursor_x,
	output logic [COORD_BITS-1:0] cursor_y,
	output logic [2:0]            button_bits,
	output logic signed [8:0]     move_x,
	output logic signed [8:0]     move_y,
	output logic                  x_overflowed,
	output logic                  y_overflowed
);
	import ps2mc_pkg::*;

	localparam int SW = COORD_BITS + 2;

	logic                   out_valid_q;
	logic [COORD_BITS-1:0]  pos_x_q;
	logic [COORD_BITS-1:0]  pos_y_q;
	logic [COORD_BITS-1:0]  cur_x_q;
	logic [COORD_BITS-1:0]  cur_y_q;
	logic [2:0]             btn_q;
	logic signed [8:0]      dx_q;
	logic signed [8:0]      dy_q;
	logic                   xo_q;
	logic                   yo_q;

	logic                   xo;
	logic                   yo;
	logic signed [8:0]      dx;
	logic signed [8:0]      dy;
	logic signed [SW-1:0]   sum_x;
	logic signed [SW-1:0]   sum_y;
	logic [COORD_BITS-1:0]  new_x;
	logic [COORD_BITS-1:0]  new_y;

	// Take a packet when the output register is free or draining
	assign pop = ~queue_empty & (~out_valid_q | out_ready);

	// Deltas: overflow forces zero, sign bit is the ninth bit
	assign xo = pkt.header[HDR_X_OVF_BIT];
	assign yo = pkt.header[HDR_Y_OVF_BIT];
	assign dx = xo ? '0 : $signed({pkt.header[HDR_X_SIGN_BIT], pkt.x_byte});
	assign dy = yo ? '0 : $signed({pkt.header[HDR_Y_SIGN_BIT], pkt.y_byte});

	// Move: X adds, Y subtracts (screen rows grow downward)
	assign sum_x = $signed({2'b00, pos_x_q}) + SW'(dx);
	assign sum_y = $signed({2'b00, pos_y_q}) - SW'(dy);

	// Clamp to 0 .. limit
	always_comb begin
		if (sum_x[SW-1]) begin
			new_x = '0;
		end else if (sum_x > $signed({2'b00, lim_x})) begin
			new_x = lim_x;
		end else begin
			new_x = sum_x[COORD_BITS-1:0];
		end
		if (sum_y[SW-1]) begin
			new_y = '0;
		end else if (sum_y > $signed({2'b00, lim_y})) begin
			new_y = lim_y;
		end else begin
			new_y = sum_y[COORD_BITS-1:0];
		end
	end

	// Control and cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				pos_x_q     <= new_x;
				pos_y_q     <= new_y;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_x_q <= new_x;
			cur_y_q <= new_y;
			btn_q   <= pkt.header[BUTTON_BITS-1:0];
			dx_q    <= dx;
			dy_q    <= dy;
			xo_q    <= xo;
			yo_q    <= yo;
		end
	end

	assign out_valid    = out_valid_q;
	assign cursor_x     = cur_x_q;
	assign cursor_y     = cur_y_q;
	assign button_bits  = btn_q;
	assign move_x       = dx_q;
	assign move_y       = dy_q;
	assign x_overflowed = xo_q;
	assign y_overflowed = yo_q;

	a_cursor_tracks_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (cur_x_q == pos_x_q && cur_y_q == pos_y_q))
		else $error("shown cursor differs from kept position");
	a_ovf_zero_delta: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (xo_q || yo_q)) |->
		((!xo_q || dx_q == '0) && (!yo_q || dy_q == '0)))
		else $error("overflowed delta is not zero");
	a_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (pos_x_q <= $past(lim_x) && pos_y_q <= $past(lim_y)))
		else $error("cursor left the screen");

endmodule

/* hw/rtl/ps2_mouse_packet_cursor_tracker.sv */
`timescale 1ns / 1ps
// PS/2 mouse packet cursor tracker, top level: stream ports and screen size registers.
// Depends on ps2mc_pkg, ps2mc_front, ps2mc_fifo and ps2mc_back.
//
// Accepts one controller byte per clock on the slave stream while the queue has room
// (tuser marks bytes from the auxiliary port; others are dropped). Every third aux byte
// of a framed packet produces one result word on the master stream, registered behind the
// packet queue, holding the clamped cursor, buttons, deltas and overflow flags. The front
// framer takes a byte every cycle while the two-entry packet queue has room; the back end
// retires one packet per cycle into its output register while it is free or draining, so
// the sustained rate is one byte per clock while m_tready is high. Screen sizes are written
// through the cfg channel (always ready) and take effect on the next clock; write them only
// while no packet is in flight. No clearing pass is needed after reset.
module ps2_mouse_packet_cursor_tracker #(
	parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF,
	localparam int OUT_W = ((2 * COORD_BITS + 23 + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] data_byte
	input  logic                          s_tuser,   // [0] from_aux
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// low to high: cursor_x, cursor_y, button_bits, move_x, move_y,
	// x_overflowed, y_overflowed, zero fill
	output logic [OUT_W-1:0]              m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  ps2mc_pkg::cfg_reg_t           cfg_index,
	input  logic [ps2mc_pkg::SIZE_BITS-1:0] cfg_data
);
	import ps2mc_pkg::*;

	localparam int PAD_W = OUT_W - (2 * COORD_BITS + 23);
	localparam logic [15:0] LIM_X_RST = size_to_limit(SCREEN_WIDTH_RST, COORD_BITS);
	localparam logic [15:0] LIM_Y_RST = size_to_limit(SCREEN_HEIGHT_RST, COORD_BITS);

	logic [COORD_BITS-1:0] lim_x_q;
	logic [COORD_BITS-1:0] lim_y_q;
	logic [15:0]           cfg_lim;

	logic                  push;
	pkt_t                  push_pkt;
	logic                  pop;
	logic [$bits(pkt_t)-1:0] head_raw;
	pkt_t                  head_pkt;
	logic                  q_full;
	logic                  q_empty;

	logic [COORD_BITS-1:0] cursor_x;
	logic [COORD_BITS-1:0] cursor_y;
	logic [2:0]            button_bits;
	logic signed [8:0]     move_x;
	logic signed [8:0]     move_y;
	logic                  x_overflowed;
	logic                  y_overflowed;

	// Screen size registers, kept as the highest legal coordinate
	assign cfg_ready = 1'b1;
	assign cfg_lim   = size_to_limit(cfg_data, COORD_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_x_q <= LIM_X_RST[COORD_BITS-1:0];
			lim_y_q <= LIM_Y_RST[COORD_BITS-1:0];
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SCREEN_WIDTH: begin
					lim_x_q <= cfg_lim[COORD_BITS-1:0];
				end
				CFG_SCREEN_HEIGHT: begin
					lim_y_q <= cfg_lim[COORD_BITS-1:0];
				end
				default: begin
					lim_x_q <= lim_x_q;
				end
			endcase
		end
	end

	// Packet framer
	ps2mc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.data_byte  (s_tdata),
		.from_aux   (s_tuser),
		.queue_full (q_full),
		.push       (push),
		.push_pkt   (push_pkt)
	);

	// Packet queue
	ps2mc_fifo #(
		.WIDTH ($bits(pkt_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_pkt),
		.pop    (pop),
		.rdata  (head_raw),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign head_pkt = pkt_t'(head_raw);

	// Decode and cursor update
	ps2mc_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pkt          (head_pkt),
		.queue_empty  (q_empty),
		.pop          (pop),
		.lim_x        (lim_x_q),
		.lim_y        (lim_y_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.cursor_x     (cursor_x),
		.cursor_y     (cursor_y),
		.button_bits  (button_bits),
		.move_x       (move_x),
		.move_y       (move_y),
		.x_overflowed (x_overflowed),
		.y_overflowed (y_overflowed)
	);

	// Result word packing
	assign m_tdata = {{PAD_W{1'b0}}, y_overflowed, x_overflowed, move_y, move_x,
		button_bits, cursor_y, cursor_x};

endmodule
